>>> src/lns_pkg.sv
// Package for the leaky integrate-and-fire neuron with stimulus generator.
// Holds the shared types, configuration register layout and the quarter-wave sine table.
// No dependencies.
package lns_pkg;

  // Signed width of membrane, drive and threshold values.
  localparam int ValueWidth = 24;
  // Quarter-wave sine table depth; the table holds SineTableDepth + 1 entries.
  localparam int SineTableDepth = 256;
  localparam int SineIdxWidth = $clog2(SineTableDepth + 1);
  // Default depth of the queue between the stimulus front end and the membrane back end.
  localparam int QueueDepth = 2;
  localparam int CfgIndexWidth = 3;

  // pi/2 in Q30.
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef logic signed [ValueWidth-1:0] value_t;

  typedef enum logic [1:0] {
    WAVE_CONST = 2'd0,
    WAVE_STEP  = 2'd1,
    WAVE_SINE  = 2'd2,
    WAVE_PULSE = 2'd3
  } waveform_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_LEAK_COEF     = 3'd0,
    CFG_THRESHOLD     = 3'd1,
    CFG_RESET_LEVEL   = 3'd2,
    CFG_WAVEFORM_MODE = 3'd3,
    CFG_DRIVE_LOW     = 3'd4,
    CFG_DRIVE_HIGH    = 3'd5,
    CFG_STEP_LENGTH   = 3'd6,
    CFG_PHASE_STEP    = 3'd7
  } cfg_index_e;

  typedef struct packed {
    logic [15:0]       leak_coef;
    value_t            threshold;
    value_t            reset_level;
    waveform_e         waveform_mode;
    value_t            drive_low;
    value_t            drive_high;
    logic [23:0]       step_length;
    logic [15:0]       phase_step;
  } cfg_t;

  // One tick as it travels from the front end to the back end.
  typedef struct packed {
    logic   start_run;
    value_t drive;
  } stim_t;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef logic [15:0] sine_rom_t [SineTableDepth+1];

  // Builds the quarter-wave table: sin(pi/2 * k / depth) by a Q30 Taylor series,
  // rounded to Q15 and clamped to one.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    for (int k = 0; k <= SineTableDepth; k++) begin
      x    = (64'(k) * HalfPiQ30) / SineTableDepth;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - $signed(term);
      if (sum < 0) begin
        sum = '0;
      end
      q = ($unsigned(sum) + 64'd16384) >> 15;
      if (q > 64'd32768) begin
        q = 64'd32768;
      end
      rom[k] = q[15:0];
    end
    return rom;
  endfunction

endpackage

>>> src/lns_front.sv
// Stimulus front end: accepts ticks, keeps the tick, pulse and phase counters
// and computes the drive level in three stages. Depends on lns_pkg.
module lns_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lns_pkg::cfg_t         cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  start_run_i,
  input  logic                  full_i,
  output logic                  push_o,
  output lns_pkg::stim_t        item_o
);

  localparam int IdxW = lns_pkg::SineIdxWidth;
  localparam int IdxProdW = 14 + IdxW;
  localparam lns_pkg::sine_rom_t SineRom = lns_pkg::build_sine_rom();

  // Generator state.
  logic [23:0] tick_q, tick_d;
  logic [23:0] pcnt_q, pcnt_d;
  logic        phigh_q, phigh_d;
  logic [15:0] phase_q, phase_d;

  // Stage A: drive choice and sine table address.
  logic                   a_valid_q, a_start_q, a_sine_q, a_neg_q;
  lns_pkg::value_t        a_drive_q, a_drive_d;
  logic [IdxW-1:0]        a_idx_q, a_idx_d;
  // Stage B: signed sine sample.
  logic                   b_valid_q, b_start_q, b_sine_q;
  lns_pkg::value_t        b_drive_q;
  logic signed [16:0]     b_sin_q;
  // Stage C: amplitude product.
  logic                   c_valid_q, c_start_q, c_sine_q;
  lns_pkg::value_t        c_drive_q;
  logic signed [40:0]     c_prod_q;

  logic a_load, b_load, c_load, accept;
  logic [23:0] tick_cur, pcnt_cur, half;
  logic        phigh_cur;
  logic [15:0] phase_cur;
  logic [24:0] pcnt_inc;
  logic [IdxProdW-1:0] idx_prod;
  logic [IdxW-1:0]     idx_raw;
  logic [15:0]         rom_val;
  logic signed [41:0]  rnd_sum;
  logic signed [26:0]  rnd_val;
  lns_pkg::value_t     sine_drive;

  // Stage handshakes: a stage loads when empty or when its contents move on.
  assign push_o     = c_valid_q && !full_i;
  assign c_load     = !c_valid_q || !full_i;
  assign b_load     = !b_valid_q || c_load;
  assign a_load     = !a_valid_q || b_load;
  assign in_ready_o = a_load;
  assign accept     = in_valid_i && in_ready_o;

  // Counter update and drive selection for the tick being accepted.
  always_comb begin
    tick_cur  = start_run_i ? '0 : tick_q;
    pcnt_cur  = start_run_i ? '0 : pcnt_q;
    phigh_cur = start_run_i ? 1'b1 : phigh_q;
    phase_cur = start_run_i ? '0 : phase_q;

    tick_d  = (tick_cur != '1) ? tick_cur + 24'd1 : tick_cur;
    phase_d = phase_cur + cfg_i.phase_step;

    half     = (cfg_i.step_length == '0) ? 24'd1 : cfg_i.step_length;
    pcnt_inc = 25'(pcnt_cur) + 25'd1;
    pcnt_d   = pcnt_cur;
    phigh_d  = phigh_cur;

    case (cfg_i.waveform_mode)
      lns_pkg::WAVE_CONST: begin
        a_drive_d = cfg_i.drive_high;
      end
      lns_pkg::WAVE_STEP: begin
        a_drive_d = (tick_cur >= cfg_i.step_length) ? cfg_i.drive_high : cfg_i.drive_low;
      end
      lns_pkg::WAVE_PULSE: begin
        a_drive_d = phigh_cur ? cfg_i.drive_high : cfg_i.drive_low;
        if (pcnt_inc >= 25'(half)) begin
          pcnt_d  = '0;
          phigh_d = !phigh_cur;
        end else begin
          pcnt_d = pcnt_inc[23:0];
        end
      end
      default: begin
        a_drive_d = cfg_i.drive_high;
      end
    endcase

    // Table address within the quarter wave, mirrored on odd quadrants.
    idx_prod = IdxProdW'(phase_cur[13:0]) * IdxProdW'(lns_pkg::SineTableDepth);
    idx_raw  = idx_prod[IdxProdW-1:14];
    a_idx_d  = phase_cur[14] ? IdxW'(lns_pkg::SineTableDepth) - idx_raw : idx_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      pcnt_q  <= '0;
      phigh_q <= 1'b1;
      phase_q <= '0;
    end else if (accept) begin
      tick_q  <= tick_d;
      pcnt_q  <= pcnt_d;
      phigh_q <= phigh_d;
      phase_q <= phase_d;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_q <= in_valid_i;
      end
      if (b_load) begin
        b_valid_q <= a_valid_q;
      end
      if (c_load) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  assign rom_val = SineRom[a_idx_q];

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_start_q <= start_run_i;
      a_sine_q  <= (cfg_i.waveform_mode == lns_pkg::WAVE_SINE);
      a_drive_q <= a_drive_d;
      a_idx_q   <= a_idx_d;
      a_neg_q   <= phase_cur[15];
    end
    if (b_load) begin
      b_start_q <= a_start_q;
      b_sine_q  <= a_sine_q;
      b_drive_q <= a_drive_q;
      b_sin_q   <= a_neg_q ? -$signed({1'b0, rom_val}) : $signed({1'b0, rom_val});
    end
    if (c_load) begin
      c_start_q <= b_start_q;
      c_sine_q  <= b_sine_q;
      c_drive_q <= b_drive_q;
      c_prod_q  <= cfg_i.drive_high * b_sin_q;
    end
  end

  // Round the product back to Q7.16 and saturate.
  always_comb begin
    rnd_sum = 42'(c_prod_q) + 42'sd16384;
    rnd_val = rnd_sum[41:15];
    if (rnd_val > 27'sd8388607) begin
      sine_drive = 24'sh7FFFFF;
    end else if (rnd_val < -27'sd8388608) begin
      sine_drive = 24'sh800000;
    end else begin
      sine_drive = rnd_val[23:0];
    end
    item_o.start_run = c_start_q;
    item_o.drive     = c_sine_q ? sine_drive : c_drive_q;
  end

endmodule

>>> src/lns_queue.sv
// Small item queue between the stimulus front end and the membrane back end.
// Depends on lns_pkg.
module lns_queue #(
  parameter int QUEUE_DEPTH = lns_pkg::QueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lns_pkg::stim_t       item_i,
  input  logic                 pop_i,
  output lns_pkg::stim_t       item_o,
  output lns_pkg::queue_stat_t stat_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  lns_pkg::stim_t entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign stat_o.full  = (count_q == CntW'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign item_o       = entry_q[rd_ptr_q];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> src/lns_back.sv
// Membrane back end: leaky integration, saturation, threshold and the result register.
// Depends on lns_pkg.
module lns_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lns_pkg::cfg_t        cfg_i,
  input  lns_pkg::queue_stat_t stat_i,
  input  lns_pkg::stim_t       item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 spike_o,
  output lns_pkg::value_t      membrane_level_o,
  output lns_pkg::value_t      drive_level_o
);

  lns_pkg::value_t    membrane_q, membrane_d;
  lns_pkg::value_t    mem_cur, v_sat;
  logic               out_valid_q, spike_d;
  logic signed [40:0] leak_prod;
  logic signed [41:0] leak_sum;
  logic signed [25:0] leak_val;
  logic signed [26:0] v_sum;

  // Take an item whenever the result register is free or being emptied.
  assign pop_o       = !stat_i.empty && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // One tick of the membrane: leak, add drive, saturate, fire.
  always_comb begin
    mem_cur   = item_i.start_run ? '0 : membrane_q;
    leak_prod = $signed({1'b0, cfg_i.leak_coef}) * mem_cur;
    leak_sum  = 42'(leak_prod) + 42'sd32768;
    leak_val  = leak_sum[41:16];
    v_sum     = 27'(mem_cur) - 27'(leak_val) + 27'(item_i.drive);
    if (v_sum > 27'sd8388607) begin
      v_sat = 24'sh7FFFFF;
    end else if (v_sum < -27'sd8388608) begin
      v_sat = 24'sh800000;
    end else begin
      v_sat = v_sum[23:0];
    end
    spike_d    = (v_sat >= cfg_i.threshold);
    membrane_d = spike_d ? cfg_i.reset_level : v_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      membrane_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        membrane_q  <= membrane_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      spike_o          <= spike_d;
      membrane_level_o <= membrane_d;
      drive_level_o    <= item_i.drive;
    end
  end

endmodule

>>> src/lif_neuron_with_stimulus.sv
// Top level of the leaky integrate-and-fire neuron with stimulus generator.
// Holds the configuration registers; uses lns_pkg, lns_front, lns_queue and lns_back.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   start_run_i
//   out       output     out_valid_o / out_ready_i spike_o, membrane_level_o, drive_level_o
//   cfg       input      cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// One item is taken every cycle while neither side stalls; the membrane update (one
// multiply-add with a compare on the stored potential) is combinational.
// An accepted item passes front stages A, B, C, the queue and the result register.
// Reset loads the register defaults and the counters; no clearing pass is needed.
// Either side may stall; the queue lets the front end keep working meanwhile.
module lif_neuron_with_stimulus #(
  parameter int QUEUE_DEPTH = lns_pkg::QueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                start_run_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                spike_o,
  output logic signed [23:0]                  membrane_level_o,
  output logic signed [23:0]                  drive_level_o,
  input  logic                                cfg_we_i,
  input  logic [lns_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [23:0]                         cfg_data_i
);

  lns_pkg::cfg_t        cfg_q;
  lns_pkg::stim_t       front_item, head_item;
  lns_pkg::queue_stat_t q_stat;
  logic                 front_push, back_pop;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leak_coef     <= 16'd6554;
      cfg_q.threshold     <= 24'sd983040;
      cfg_q.reset_level   <= '0;
      cfg_q.waveform_mode <= lns_pkg::WAVE_CONST;
      cfg_q.drive_low     <= '0;
      cfg_q.drive_high    <= '0;
      cfg_q.step_length   <= 24'd1;
      cfg_q.phase_step    <= '0;
    end else if (cfg_we_i) begin
      case (lns_pkg::cfg_index_e'(cfg_index_i))
        lns_pkg::CFG_LEAK_COEF:     cfg_q.leak_coef     <= cfg_data_i[15:0];
        lns_pkg::CFG_THRESHOLD:     cfg_q.threshold     <= cfg_data_i;
        lns_pkg::CFG_RESET_LEVEL:   cfg_q.reset_level   <= cfg_data_i;
        lns_pkg::CFG_WAVEFORM_MODE: begin
          cfg_q.waveform_mode <= lns_pkg::waveform_e'(cfg_data_i[1:0]);
        end
        lns_pkg::CFG_DRIVE_LOW:     cfg_q.drive_low     <= cfg_data_i;
        lns_pkg::CFG_DRIVE_HIGH:    cfg_q.drive_high    <= cfg_data_i;
        lns_pkg::CFG_STEP_LENGTH:   cfg_q.step_length   <= cfg_data_i;
        lns_pkg::CFG_PHASE_STEP:    cfg_q.phase_step    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Stimulus front end.
  lns_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_run_i (start_run_i),
    .full_i      (q_stat.full),
    .push_o      (front_push),
    .item_o      (front_item)
  );

  // Decoupling queue.
  lns_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .item_i (front_item),
    .pop_i  (back_pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  // Membrane back end.
  lns_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .stat_i           (q_stat),
    .item_i           (head_item),
    .pop_o            (back_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .spike_o          (spike_o),
    .membrane_level_o (membrane_level_o),
    .drive_level_o    (drive_level_o)
  );

`ifndef SYNTHESIS
  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_stat.full |-> !front_push)
    else $error("item pushed into a full queue");

  // The back end never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_stat.empty |-> !back_pop)
    else $error("item popped from an empty queue");

  // A new result only appears after an item left the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_pop))
    else $error("result appeared without a queue pop");
`endif

endmodule
